FILE: rtl/core/ntsc_pkg.sv
// ============================================================================
// ntsc_pkg: shared definitions for the nearest track side classifier
// Widths, operation and register codes, course codes and the control
// struct that drives the distance unit.
// ============================================================================
package ntsc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int POINT_W    = 2 * COORD_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int OP_W       = 2;
    localparam int COURSE_W   = 2;
    localparam int REG_IDX_W  = 1;

    localparam logic [OP_W-1:0] OP_WR_INNER = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_OUTER = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_INNER_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_OUTER_COUNT = 1'b1;

    localparam logic [COURSE_W-1:0] COURSE_INNER = 2'd1;
    localparam logic [COURSE_W-1:0] COURSE_OUTER = 2'd2;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_POINTS);

    typedef logic [POINT_W-1:0] point_t;
    typedef logic [DIST_W-1:0]  dist_t;

    // control from the sequencer to one distance unit
    typedef struct packed {
        logic clr;   // restart the running minimum
        logic vld;   // point on the input is part of the scan
    } scan_ctrl_t;

endpackage

FILE: rtl/core/ntsc_dist_unit.sv
// ============================================================================
// ntsc_dist_unit: squared distance and running minimum
// Three register stages (absolute difference, squares, sum) feed a compare
// that keeps the least squared distance seen since the last clear.
// ============================================================================
module ntsc_dist_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ntsc_pkg::scan_ctrl_t                ctrl,
    input  ntsc_pkg::point_t                    point,
    input  logic signed [ntsc_pkg::COORD_W-1:0] qx,
    input  logic signed [ntsc_pkg::COORD_W-1:0] qy,
    output logic                                busy,
    output ntsc_pkg::dist_t                     min_dist
);
    import ntsc_pkg::*;

    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    logic [COORD_W:0]          abs_x;
    logic [COORD_W:0]          abs_y;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    dist_t              sum_reg;
    dist_t              min_reg;
    dist_t              min_next;

    assign px     = point[POINT_W-1:COORD_W];
    assign py     = point[COORD_W-1:0];
    assign diff_x = {px[COORD_W-1], px} - {qx[COORD_W-1], qx};
    assign diff_y = {py[COORD_W-1], py} - {qy[COORD_W-1], qy};
    assign abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
    assign abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= abs_x[COORD_W-1:0];
        dy_reg  <= abs_y[COORD_W-1:0];
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_comb
    begin
        min_next = min_reg;
        if (ctrl.clr)
            min_next = '1;
        else if (v3_reg && (sum_reg < min_reg))
            min_next = sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= '1;
        else
            min_reg <= min_next;
    end

    assign busy     = v1_reg | v2_reg | v3_reg;
    assign min_dist = min_reg;

endmodule

FILE: rtl/core/nearest_track_side_classifier.sv
// ============================================================================
// nearest_track_side_classifier: two-course nearest point classifier
// Holds inner and outer course point tables and answers which course lies
// nearest to a query position, by least squared distance.
// ============================================================================
// Usage:
//   item channel (item_valid/item_ready): operation 0 or 1 writes the point
//   (x_coord, y_coord) into slot index of the inner or outer table and
//   gives no result. Operation 2 starts a query.
//   Operation 3 is dropped.
//   result channel (result_valid/result_ready): one course per query,
//   1 when the inner course is nearer, 2 when the outer course is nearer
//   or at equal distance. An empty table counts as infinitely far.
//   Both tables are read in the same cycle, one slot each, and go through
//   one distance unit per table; a query scans N slots, N being the larger
//   clamped count, then waits until both distance units have drained before
//   the verdict goes to the output register; with both counts zero it skips
//   the scan. A new query is taken only after the previous one is done.
//   item_ready is low for the whole scan; a new transaction can enter once
//   the result sits in the output register, even while it is stalled.
//   Counts must be set on the cfg port only while idle; the block does not
//   enforce it. Reset zeroes both; table contents are undefined until written.
// ============================================================================
module nearest_track_side_classifier (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [ntsc_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [ntsc_pkg::CNT_W-1:0]            cfg_data,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic [ntsc_pkg::OP_W-1:0]             operation,
    input  logic [ntsc_pkg::ADDR_W-1:0]           index,
    input  logic signed [ntsc_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [ntsc_pkg::COORD_W-1:0]   y_coord,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [ntsc_pkg::COURSE_W-1:0]         course
);
    import ntsc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic [CNT_W-1:0]    scan_cnt_next;
    logic [CNT_W-1:0]    inner_count_reg;
    logic [CNT_W-1:0]    outer_count_reg;
    logic [CNT_W-1:0]    inner_n;
    logic [CNT_W-1:0]    outer_n;
    logic [CNT_W-1:0]    scan_len;
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COURSE_W-1:0] course_reg;
    logic [COURSE_W-1:0] course_next;
    logic [COURSE_W-1:0] verdict;

    point_t              inner_mem [MAX_POINTS];
    point_t              outer_mem [MAX_POINTS];
    point_t              rd_inner_reg;
    point_t              rd_outer_reg;
    logic                rd_inner_vld_reg;
    logic                rd_outer_vld_reg;

    logic                accept;
    logic                start_query;
    logic                wr_inner;
    logic                wr_outer;
    logic                issue;
    logic                issue_inner;
    logic                issue_outer;
    logic [ADDR_W-1:0]   rd_addr;
    scan_ctrl_t          inner_ctrl;
    scan_ctrl_t          outer_ctrl;
    logic                inner_busy;
    logic                outer_busy;
    dist_t               inner_min;
    dist_t               outer_min;
    logic                pipe_busy;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_count_reg <= '0;
            outer_count_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_INNER_COUNT: inner_count_reg <= cfg_data;
                REG_OUTER_COUNT: outer_count_reg <= cfg_data;
            endcase
        end
    end

    // clamp counts to the table depth
    assign inner_n  = (inner_count_reg > MAX_COUNT) ? MAX_COUNT : inner_count_reg;
    assign outer_n  = (outer_count_reg > MAX_COUNT) ? MAX_COUNT : outer_count_reg;
    assign scan_len = (inner_n > outer_n) ? inner_n : outer_n;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign item_ready  = (state_reg == ST_IDLE);
    assign accept      = item_valid & item_ready;
    assign start_query = accept & (operation == OP_QUERY);
    assign wr_inner    = accept & (operation == OP_WR_INNER);
    assign wr_outer    = accept & (operation == OP_WR_OUTER);

    assign issue       = (state_reg == ST_SCAN);
    assign issue_inner = issue & (scan_cnt_reg < inner_n);
    assign issue_outer = issue & (scan_cnt_reg < outer_n);
    assign rd_addr     = scan_cnt_reg[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // Point tables
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_inner)
            inner_mem[index] <= {x_coord, y_coord};
        rd_inner_reg <= inner_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_outer)
            outer_mem[index] <= {x_coord, y_coord};
        rd_outer_reg <= outer_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_inner_vld_reg <= 1'b0;
            rd_outer_vld_reg <= 1'b0;
        end
        else
        begin
            rd_inner_vld_reg <= issue_inner;
            rd_outer_vld_reg <= issue_outer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            qx_reg <= x_coord;
            qy_reg <= y_coord;
        end
    end

    // ------------------------------------------------------------------
    // Distance units
    // ------------------------------------------------------------------
    assign inner_ctrl = '{clr: start_query, vld: rd_inner_vld_reg};
    assign outer_ctrl = '{clr: start_query, vld: rd_outer_vld_reg};

    ntsc_dist_unit u_inner_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (inner_ctrl),
        .point    (rd_inner_reg),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .busy     (inner_busy),
        .min_dist (inner_min)
    );

    ntsc_dist_unit u_outer_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (outer_ctrl),
        .point    (rd_outer_reg),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .busy     (outer_busy),
        .min_dist (outer_min)
    );

    assign pipe_busy = rd_inner_vld_reg | rd_outer_vld_reg | inner_busy | outer_busy;

    // empty table counts as infinitely far; both empty gives inner
    always_comb
    begin
        if (inner_n == '0)
            verdict = (outer_n == '0) ? COURSE_INNER : COURSE_OUTER;
        else if (outer_n == '0)
            verdict = COURSE_INNER;
        else
            verdict = (inner_min >= outer_min) ? COURSE_OUTER : COURSE_INNER;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg & ~result_ready;
        course_next    = course_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_query)
                begin
                    scan_cnt_next = '0;
                    state_next    = (scan_len == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == scan_len - 1'b1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    course_next    = verdict;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        course_reg <= course_next;
    end

    assign result_valid = out_valid_reg;
    assign course       = course_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg < scan_len))
        else $error("scan counter ran past the scan length");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("distance pipeline busy while idle");

    a_course_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (course == COURSE_INNER || course == COURSE_OUTER))
        else $error("invalid course code on result");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_DRAIN) |=> pipe_busy)
        else $error("last scan slot not in the pipeline");

endmodule

FILE: tb/tb_nearest_track_side_classifier.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_nearest_track_side_classifier: self-checking testbench
// Loads the inner and outer course tables through the item channel, sets the
// point counts through the cfg port and fires queries. A scoreboard class
// predicts each course by a brute-force least squared distance search over
// both tables and checks every result in order. Both channels idle and
// stall at random.
// ============================================================================
module tb_nearest_track_side_classifier;

    import ntsc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              LOAD_SLOTS = 128;

    class track_side_board;
        point_t              inner_tab [MAX_POINTS];
        point_t              outer_tab [MAX_POINTS];
        logic [CNT_W-1:0]    inner_cnt;
        logic [CNT_W-1:0]    outer_cnt;
        logic [COURSE_W-1:0] expected_courses [$];
        int                  errors;
        int                  queries;
        int                  point_writes;
        int                  checked;

        function new();
            inner_cnt    = '0;
            outer_cnt    = '0;
            errors       = 0;
            queries      = 0;
            point_writes = 0;
            checked      = 0;
        endfunction

        function void set_count(logic [REG_IDX_W-1:0] sel, logic [CNT_W-1:0] val);
            if (sel == REG_INNER_COUNT)
                inner_cnt = val;
            else
                outer_cnt = val;
        endfunction

        function longint unsigned sq_dist(point_t p, logic signed [COORD_W-1:0] qx,
                                          logic signed [COORD_W-1:0] qy);
            longint dx;
            longint dy;
            dx = longint'($signed(p[POINT_W-1:COORD_W])) - longint'(qx);
            dy = longint'($signed(p[COORD_W-1:0])) - longint'(qy);
            return longint'(dx * dx + dy * dy);
        endfunction

        function logic [COURSE_W-1:0] nearest_course(logic signed [COORD_W-1:0] qx,
                                                     logic signed [COORD_W-1:0] qy);
            int              ni;
            int              no;
            longint unsigned mi;
            longint unsigned mo;
            longint unsigned d;
            ni = (inner_cnt > MAX_COUNT) ? MAX_POINTS : int'(inner_cnt);
            no = (outer_cnt > MAX_COUNT) ? MAX_POINTS : int'(outer_cnt);
            // an empty table is infinitely far away
            if (ni == 0)
                return (no == 0) ? COURSE_INNER : COURSE_OUTER;
            if (no == 0)
                return COURSE_INNER;
            mi = '1;
            mo = '1;
            for (int i = 0; i < ni; i++)
            begin
                d = sq_dist(inner_tab[i], qx, qy);
                if (d < mi)
                    mi = d;
            end
            for (int i = 0; i < no; i++)
            begin
                d = sq_dist(outer_tab[i], qx, qy);
                if (d < mo)
                    mo = d;
            end
            // a tie goes to the outer course
            return (mi >= mo) ? COURSE_OUTER : COURSE_INNER;
        endfunction

        function void note_transaction(logic [OP_W-1:0] op, logic [ADDR_W-1:0] idx,
                                       logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y);
            if (op == OP_WR_INNER)
            begin
                inner_tab[idx] = {x, y};
                point_writes++;
            end
            else if (op == OP_WR_OUTER)
            begin
                outer_tab[idx] = {x, y};
                point_writes++;
            end
            else if (op == OP_QUERY)
            begin
                expected_courses.push_back(nearest_course(x, y));
                queries++;
            end
        endfunction

        function void check_course(logic [COURSE_W-1:0] actual);
            logic [COURSE_W-1:0] exp_course;
            if (expected_courses.size() == 0)
            begin
                $display("%0t: course %0d arrived with nothing expected", $time, actual);
                errors++;
                return;
            end
            exp_course = expected_courses.pop_front();
            checked++;
            if (actual !== exp_course)
            begin
                $display("%0t: course mismatch: expected %0d, actual %0d",
                         $time, exp_course, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_courses.size();
        endfunction
    endclass

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_write_en = 1'b0;
    logic [REG_IDX_W-1:0]       cfg_index    = '0;
    logic [CNT_W-1:0]           cfg_data     = '0;
    logic                       item_valid   = 1'b0;
    logic                       item_ready;
    logic [OP_W-1:0]            operation    = '0;
    logic [ADDR_W-1:0]          index        = '0;
    logic signed [COORD_W-1:0]  x_coord      = '0;
    logic signed [COORD_W-1:0]  y_coord      = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic [COURSE_W-1:0]        course;

    track_side_board sb = new();
    bit              idle_on = 1'b1;
    int              settings_run = 0;

    nearest_track_side_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .index        (index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .course       (course)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int                        r;
        logic signed [COORD_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0:       c = 16'sh8000;
                1:       c = 16'sh7fff;
                2:       c = '0;
                default: c = '1;
            endcase
        end
        else if (r < 50)
            c = COORD_W'($urandom_range(0, 1023) - 512);   // cluster near origin
        else
            c = COORD_W'($urandom);
        return c;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] idx,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        index      <= idx;
        x_coord    <= x;
        y_coord    <= y;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_transaction(op, idx, x, y);
    endtask

    // drop valid and wait until every course is back and writes have landed
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_counts(input logic [CNT_W-1:0] ci, input logic [CNT_W-1:0] co);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_INNER_COUNT;
        cfg_data     <= ci;
        @(posedge clk);
        sb.set_count(REG_INNER_COUNT, ci);
        cfg_index    <= REG_OUTER_COUNT;
        cfg_data     <= co;
        @(posedge clk);
        sb.set_count(REG_OUTER_COUNT, co);
        cfg_write_en <= 1'b0;
        settings_run++;
    endtask

    task automatic run_random(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_item(OP_W'($urandom_range(0, 1)),
                          ADDR_W'($urandom_range(0, LOAD_SLOTS - 1)),
                          rand_coord(), rand_coord());
            else if (r < 95)
                send_item(OP_QUERY, ADDR_W'($urandom), rand_coord(), rand_coord());
            else
                send_item(OP_UNUSED, ADDR_W'($urandom), rand_coord(), rand_coord());
        end
    endtask

    // result side: check each transaction, stall at random
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                sb.check_course(course);
            if (!idle_on)
            begin
                stall_left = 0;
                result_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    result_ready <= 1'b1;
                else
                begin
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(8, 40);
                    result_ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        logic [CNT_W-1:0] ci;
        logic [CNT_W-1:0] co;
        int               n;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // both tables empty after reset
        send_item(OP_QUERY, '0, 16'sd0, 16'sd0);
        send_item(OP_QUERY, '1, 16'sh8000, 16'sh7fff);
        send_item(OP_UNUSED, 10'd5, 16'sd1, 16'sd1);
        send_item(OP_WR_INNER, 10'd0, 16'sh7fff, 16'sh7fff);
        send_item(OP_WR_INNER, 10'd1, 16'sh8000, 16'sh8000);
        send_item(OP_WR_INNER, 10'd2, 16'sd0, 16'sd0);
        send_item(OP_WR_INNER, 10'd3, 16'sd100, -16'sd200);
        send_item(OP_WR_OUTER, 10'd0, 16'sh8000, 16'sh7fff);
        send_item(OP_WR_OUTER, 10'd1, 16'sh7fff, 16'sh8000);
        send_item(OP_WR_OUTER, 10'd2, 16'sd0, 16'sd0);
        send_item(OP_WR_OUTER, 10'd3, 16'sd300, 16'sd300);
        send_item(OP_WR_INNER, 10'd1023, -16'sd1, -16'sd1);
        send_item(OP_WR_OUTER, 10'd1023, -16'sd1, -16'sd1);

        // one table empty, then the other
        settle();
        set_counts(11'd4, 11'd0);
        send_item(OP_QUERY, '0, 16'sd5, 16'sd5);
        settle();
        set_counts(11'd0, 11'd4);
        send_item(OP_QUERY, '0, 16'sd5, 16'sd5);

        // tie, exact hits on each course, far corners
        settle();
        set_counts(11'd4, 11'd4);
        send_item(OP_QUERY, '0, 16'sd0, 16'sd0);
        send_item(OP_QUERY, '0, 16'sh7fff, 16'sh7fff);
        send_item(OP_QUERY, '0, 16'sh8000, 16'sh7fff);
        send_item(OP_QUERY, '0, 16'sd100, -16'sd199);
        send_item(OP_QUERY, '0, 16'sh8000, 16'sh8001);
        send_item(OP_QUERY, '0, 16'sd299, 16'sd301);

        // load the leading slots of both tables; counts stay within them
        idle_on = 1'b0;
        for (int i = 0; i < LOAD_SLOTS; i++)
        begin
            send_item(OP_WR_INNER, ADDR_W'(i), rand_coord(), rand_coord());
            send_item(OP_WR_OUTER, ADDR_W'(i), rand_coord(), rand_coord());
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    ci = 11'd1;     co = 11'd1;      n = 60;
                end
                1:
                begin
                    ci = CNT_W'(LOAD_SLOTS);
                    co = CNT_W'(LOAD_SLOTS);
                    n  = 12;
                end
                2:
                begin
                    ci = 11'd0;     co = 11'd7;      n = 40;
                end
                3:
                begin
                    ci = 11'd13;    co = 11'd0;      n = 40;
                end
                4:
                begin
                    ci = CNT_W'(LOAD_SLOTS);
                    co = 11'd3;
                    n  = 12;
                end
                default:
                begin
                    ci = CNT_W'($urandom_range(1, 64));
                    co = CNT_W'($urandom_range(1, 64));
                    n  = 45;
                end
            endcase
            settle();
            idle_on = (ph != 2 && ph != 6);
            set_counts(ci, co);
            run_random(n);
        end

        settle();
        $display("Covered %0d point writes and %0d queries over %0d count settings,",
                 sb.point_writes, sb.queries, settings_run);
        $display("including empty tables, ties, full scans and coordinate extremes.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
